// ===== rtl/core/bpra_pkg.sv =====
// Shared constants and the request code type for the bitmap page run allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps

package bpra_pkg;

    localparam int PAGE_W        = 14;     // width of start_page and first_page
    localparam int COUNT_W       = 15;     // width of page_count
    localparam int NUM_PAGES_DEF = 16384;  // default size of the page area
    localparam int WORD_BITS     = 8;      // map bits held in one memory word

    typedef enum logic {
        OP_RESERVE = 1'b0,
        OP_RETURN  = 1'b1
    } req_op_t;

endpackage

// ===== rtl/core/bitmap_page_run_allocator.sv =====
// First-fit allocator of contiguous page runs over a one-bit-per-page map.
// Depends on bpra_pkg for field widths and the map word size.
`timescale 1ns / 1ps

// Usage
//   Request: drive op, start_page and page_count and raise start; the item
//   is taken at a rising edge where start is high and busy is low.
//   op = 0 reserves the lowest free run of page_count pages, op = 1 returns
//   page_count pages from start_page (clipped at the end of the area).
//   Result: done is high for exactly one cycle with success, first_page and
//   double_free valid. The result cannot be held off; capture it then.
//   The used map sits in a synchronous memory of NUM_PAGES/8 (rounded up)
//   byte words, one word read and one written per cycle.
//   Flow: a zero count, an oversize reserve count, or a return starting
//   beyond the area, answers straight from idle. A return reads and rewrites
//   each word it touches. A reserve scans one word per cycle from page 0
//   until the run is found or the area ends, then rewrites the words of the run.
//   Busy is high throughout an item that touches the map.
//   Reset: after rst_n is released the block clears the map, one word a
//   cycle, with busy high; requests wait for that pass.
//   A new request may be taken in the same cycle that done is shown.
module bitmap_page_run_allocator
    import bpra_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [PAGE_W-1:0]  start_page,
    input  logic [COUNT_W-1:0] page_count,
    output logic               done,
    output logic               success,
    output logic [PAGE_W-1:0]  first_page,
    output logic               double_free
);

    localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WSH   = $clog2(WORD_BITS);
    localparam int PW    = $clog2(NUM_PAGES + 1);
    localparam int XW    = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [XW-1:0]  NP_X      = XW'(NUM_PAGES);

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_SCAN = 4'b0100,
        S_MOD  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [WAW-1:0]         addr_reg, addr_next;
    logic [WAW-1:0]         last_reg, last_next;
    logic                   issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [WAW-1:0]         pend_addr_reg, pend_addr_next;
    logic [XW-1:0]          lo_reg, lo_next;
    logic [XW-1:0]          hi_reg, hi_next;
    logic [XW-1:0]          count_reg, count_next;
    logic [XW-1:0]          run_reg, run_next;
    logic                   set_reg, set_next;
    logic                   dfree_reg, dfree_next;
    logic                   done_reg, done_next;
    logic                   success_reg, success_next;
    logic [PAGE_W-1:0]      first_reg, first_next;
    logic                   dfout_reg, dfout_next;

    // map memory
    logic [WORD_BITS-1:0]   map_mem [WORDS];
    logic [WORD_BITS-1:0]   rdata_reg;
    logic                   mem_re;
    logic                   mem_we;
    logic [WAW-1:0]         mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;

    // scan and modify datapath
    logic [XW-1:0]          scan_run;
    logic                   scan_found;
    logic [XW-1:0]          scan_end;
    logic [XW-1:0]          scan_base;
    logic [WORD_BITS-1:0]   mod_mask;
    logic [WORD_BITS-1:0]   mod_word;
    logic                   mod_hit;
    logic [XW-1:0]          req_count;
    logic [XW-1:0]          req_start;
    logic [XW-1:0]          req_sum;
    logic [XW-1:0]          req_hi;
    logic [XW-1:0]          req_last;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[addr_reg];
        end
    end

    // run tracking over one map word; pages past the area count as used
    always_comb
    begin
        logic [XW-1:0] p;
        logic          used;
        scan_run   = run_reg;
        scan_found = 1'b0;
        scan_end   = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            p    = XW'({pend_addr_reg, WSH'(j)});
            used = rdata_reg[j] | (p >= NP_X);
            if (!scan_found)
            begin
                if (used)
                begin
                    scan_run = '0;
                end
                else
                begin
                    scan_run = scan_run + XW'(1);
                    if (scan_run == count_reg)
                    begin
                        scan_found = 1'b1;
                        scan_end   = p;
                    end
                end
            end
        end
        scan_base = scan_end + XW'(1) - count_reg;
    end

    always_comb
    begin
        logic [XW-1:0] p;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            p           = XW'({pend_addr_reg, WSH'(j)});
            mod_mask[j] = (p >= lo_reg) && (p < hi_reg);
        end
        mod_word = set_reg ? (rdata_reg | mod_mask) : (rdata_reg & ~mod_mask);
        mod_hit  = |(mod_mask & ~rdata_reg);
    end

    assign req_count = XW'(page_count);
    assign req_start = XW'(start_page);
    assign req_sum   = req_start + req_count;
    assign req_hi    = (req_sum > NP_X) ? NP_X : req_sum;
    assign req_last  = req_hi - XW'(1);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = addr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        set_next       = set_reg;
        dfree_next     = dfree_reg;
        done_next      = 1'b0;
        success_next   = success_reg;
        first_next     = first_reg;
        dfout_next     = dfout_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mod_word;

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = '0;
                if (addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + WAW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    count_next = req_count;
                    addr_next  = '0;
                    issue_next = 1'b1;
                    run_next   = '0;
                    dfree_next = 1'b0;
                    if (op == OP_RESERVE)
                    begin
                        if (req_count == '0 || req_count > NP_X)
                        begin
                            done_next    = 1'b1;
                            success_next = 1'b0;
                            first_next   = '0;
                            dfout_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req_count == '0 || req_start >= NP_X)
                        begin
                            done_next    = 1'b1;
                            success_next = 1'b1;
                            first_next   = '0;
                            dfout_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = S_MOD;
                            set_next   = 1'b0;
                            lo_next    = req_start;
                            hi_next    = req_hi;
                            addr_next  = req_start[WSH +: WAW];
                            last_next  = req_last[WSH +: WAW];
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // issue reads ahead; each word is checked in the cycle after its read
                if (issue_reg)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    if (addr_reg == LAST_WORD)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + WAW'(1);
                    end
                end
                if (pend_reg)
                begin
                    run_next = scan_run;
                    if (scan_found)
                    begin
                        // drop the read in flight and mark the run
                        state_next = S_MOD;
                        set_next   = 1'b1;
                        lo_next    = scan_base;
                        hi_next    = scan_end + XW'(1);
                        addr_next  = scan_base[WSH +: WAW];
                        last_next  = scan_end[WSH +: WAW];
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                    end
                    else if (!issue_reg)
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        success_next = 1'b0;
                        first_next   = '0;
                        dfout_next   = 1'b0;
                    end
                end
            end

            S_MOD:
            begin
                // read word n while writing back word n-1: never the same entry
                if (issue_reg)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    if (addr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + WAW'(1);
                    end
                end
                if (pend_reg)
                begin
                    mem_we     = 1'b1;
                    dfree_next = dfree_reg | (mod_hit & ~set_reg);
                    if (!issue_reg)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (set_reg)
                        begin
                            success_next = 1'b1;
                            first_next   = lo_reg[PAGE_W-1:0];
                            dfout_next   = 1'b0;
                        end
                        else
                        begin
                            success_next = ~(dfree_reg | mod_hit);
                            first_next   = '0;
                            dfout_next   = dfree_reg | mod_hit;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
            first_reg   <= '0;
            dfout_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            success_reg <= success_next;
            first_reg   <= first_next;
            dfout_reg   <= dfout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        count_reg     <= count_next;
        run_reg       <= run_next;
        set_reg       <= set_next;
        dfree_reg     <= dfree_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign success     = success_reg;
    assign first_page  = first_reg;
    assign double_free = dfout_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(success && double_free))
        else $error("double free reported together with success");

    a_fail_first: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |-> (first_page == '0))
        else $error("failed item carries a non-zero first page");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && mem_we && mem_re) |-> (mem_waddr != addr_reg))
        else $error("map word read and written in the same cycle");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |=> (busy || $past(addr_reg) == LAST_WORD))
        else $error("block left the clearing pass early");
`endif

endmodule
